// ----- rtl/pfn_pkg.sv -----
// pfn_pkg: widths, constants, state types and small decode helpers
// for the polygon face normal block. No dependencies.
package pfn_pkg;

   localparam int COORD_W      = 24;            // vertex coordinate, Q12.12
   localparam int SUM_W        = 56;            // Newell accumulator
   localparam int NRM_W        = 16;            // output component, Q1.14
   localparam int MIN_LEN_W    = 20;            // threshold register
   localparam int MAX_VERTICES = 64;
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int MUL_W        = 29;            // shared multiplier operand
   localparam int LIMB_W       = 28;            // half of an accumulator magnitude
   localparam int SQ_W         = 2 * SUM_W;     // squared magnitudes and their sum
   localparam int QUO_W        = 29;            // mag^2 * 2^28 / len2, at most 2^28
   localparam int ROOT_W       = 15;            // unit component magnitude, <= 16384
   localparam int SRT_W        = 30;            // square root working width
   localparam int ONE_Q14      = 16384;

   localparam logic [3:0] SQ_OPS  = 4'd9;        // 3 components x 3 partial products
   localparam logic [3:0] ACC_OPS = 4'd3;        // 3 cross terms per pair

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_MAG,
      ST_SQ,
      ST_CHECK,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_OUT
   } pfn_state_type;

   typedef enum logic [1:0] {
      RT_IDLE,
      RT_DIV,
      RT_SQRT
   } pfn_root_state_type;

   // partial product kinds while squaring a magnitude
   typedef enum logic [1:0] {
      PP_LO_LO,
      PP_HI_LO,
      PP_HI_HI
   } pfn_part_type;

   function automatic logic [1:0] sq_comp(input logic [3:0] op);
      logic [1:0] c;
      case (op)
         4'd0, 4'd1, 4'd2: c = 2'd0;
         4'd3, 4'd4, 4'd5: c = 2'd1;
         default:          c = 2'd2;
      endcase
      return c;
   endfunction

   function automatic pfn_part_type sq_part(input logic [3:0] op);
      pfn_part_type p;
      case (op)
         4'd0, 4'd3, 4'd6: p = PP_LO_LO;
         4'd1, 4'd4, 4'd7: p = PP_HI_LO;
         default:          p = PP_HI_HI;
      endcase
      return p;
   endfunction

endpackage

// ----- rtl/pfn_req_if.sv -----
// pfn_req_if: vertex request channel (valid/ready plus vertex payload).
// Depends on pfn_pkg.
interface pfn_req_if import pfn_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;
   logic                      last_vertex;

   modport source (output valid, pos_x, pos_y, pos_z, last_vertex, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, last_vertex, output ready);
endinterface

// ----- rtl/pfn_rsp_if.sv -----
// pfn_rsp_if: face normal response channel (valid/ready plus normal payload).
// Depends on pfn_pkg.
interface pfn_rsp_if import pfn_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [NRM_W-1:0] normal_x;
   logic signed [NRM_W-1:0] normal_y;
   logic signed [NRM_W-1:0] normal_z;
   logic                    degenerate;

   modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ----- rtl/pfn_mul.sv -----
// pfn_mul: shared signed multiplier with a registered product.
// Depends on pfn_pkg.
module pfn_mul import pfn_pkg::*; (
   input  logic                    clock,
   input  logic signed [MUL_W-1:0] mul_a,
   input  logic signed [MUL_W-1:0] mul_b,
   output logic        [SUM_W-1:0] prod
);
   logic signed [2*MUL_W-1:0] full;
   logic        [SUM_W-1:0]   prod_ff;

   assign full = mul_a * mul_b;
   assign prod = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= full[SUM_W-1:0];
   end
endmodule

// ----- rtl/pfn_root.sv -----
// pfn_root: bit-serial unit giving floor(sqrt(floor(num * 2^28 / den)))
// for num <= den; restoring divide then digit-by-digit root. Depends on pfn_pkg.
module pfn_root import pfn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   num,
   input  logic [SQ_W-1:0]   den,
   output logic              done,
   output logic [ROOT_W-1:0] root
);
   pfn_root_state_type state_ff, state_in;
   logic [SQ_W:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [4:0]        step_ff, step_in;
   logic [SRT_W-1:0]  srem_ff, srem_in;
   logic [SRT_W-1:0]  res_ff, res_in;
   logic [QUO_W-1:0]  one_ff, one_in;
   logic              done_ff, done_in;

   logic [SQ_W:0]     cand;
   logic [SQ_W:0]     den_x;
   logic              ge;
   logic [SRT_W-1:0]  trial;

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RT_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      srem_ff <= srem_in;
      res_ff  <= res_in;
      one_ff  <= one_in;
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      srem_in  = srem_ff;
      res_in   = res_ff;
      one_in   = one_ff;
      done_in  = 1'b0;
      den_x    = {1'b0, den};
      cand     = (step_ff == 5'd0) ? rem_ff : {rem_ff[SQ_W-1:0], 1'b0};
      ge       = (cand >= den_x);
      trial    = res_ff + {1'b0, one_ff};

      case (state_ff)
         RT_IDLE: begin
            if (start) begin
               rem_in   = {1'b0, num};
               step_in  = 5'd0;
               state_in = RT_DIV;
            end
         end
         RT_DIV: begin
            // first step has no shift: quotient may reach 2^28 exactly
            rem_in  = ge ? (cand - den_x) : cand;
            quo_in  = {quo_ff[QUO_W-2:0], ge};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(QUO_W - 1)) begin
               srem_in  = {1'b0, quo_in};
               res_in   = '0;
               one_in   = QUO_W'(1) << (QUO_W - 1);
               state_in = RT_SQRT;
            end
         end
         RT_SQRT: begin
            if (srem_ff >= trial) begin
               srem_in = srem_ff - trial;
               res_in  = (res_ff >> 1) + {1'b0, one_ff};
            end else begin
               res_in  = res_ff >> 1;
            end
            one_in = one_ff >> 2;
            if (one_ff == QUO_W'(1)) begin
               done_in  = 1'b1;
               state_in = RT_IDLE;
            end
         end
         default: state_in = RT_IDLE;
      endcase
   end
endmodule

// ----- rtl/polygon_face_normal.sv -----
// polygon_face_normal: Newell face normal of a polygon streamed one vertex per request.
// Depends on pfn_pkg, pfn_req_if, pfn_rsp_if, pfn_mul and pfn_root.
//
// Vertices arrive in loop order (signed Q12.12), one per request, last_vertex on the
// final one. Each vertex after the first is accepted, then runs three cross terms
// through the one shared 29x29 multiplier; the first vertex is only stored. The last
// vertex also runs the closing pair, squares the three 56-bit sums in 28-bit halves on
// the same multiplier (9 products), then for each component runs the root unit, which
// does restoring division and then square root, started and waited on for done. A
// polygon that falls back skips the root unit. Requests are not taken while a vertex
// is in work. The response sits in an output register, so the next polygon can
// stream in while it waits; a finished polygon waits only if the previous response
// has not been taken. Fewer than three vertices, or a squared length not above csr
// min_length_squared, gives (0, 1.0, 0) with degenerate set.
module polygon_face_normal import pfn_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [MIN_LEN_W-1:0] csr_wr_data,
   pfn_req_if.sink              req_chan,
   pfn_rsp_if.source            rsp_chan
);
   pfn_state_type state_ff, state_in;

   logic [MIN_LEN_W-1:0]      min_len_ff, min_len_in;
   logic signed [COORD_W-1:0] first_ff [3];
   logic signed [COORD_W-1:0] first_in [3];
   logic signed [COORD_W-1:0] prev_ff  [3];
   logic signed [COORD_W-1:0] prev_in  [3];
   logic signed [COORD_W-1:0] cur_ff   [3];
   logic signed [COORD_W-1:0] cur_in   [3];
   logic [SUM_W-1:0]          sum_ff   [3];
   logic [SUM_W-1:0]          sum_in   [3];
   logic [SUM_W-1:0]          mag_ff   [3];
   logic [SUM_W-1:0]          mag_in   [3];
   logic [2:0]                neg_ff, neg_in;
   logic [SQ_W-1:0]           sq_ff    [3];
   logic [SQ_W-1:0]           sq_in    [3];
   logic [SQ_W-1:0]           len2_ff, len2_in;
   logic [ROOT_W-1:0]         q_ff     [3];
   logic [ROOT_W-1:0]         q_in     [3];
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      last_ff, last_in;
   logic                      pair_ff, pair_in;     // 0: previous->current, 1: closing
   logic [3:0]                op_ff, op_in;
   logic [1:0]                comp_ff, comp_in;
   logic                      degen_ff, degen_in;

   // response register
   logic                      rsp_vld_ff, rsp_vld_in;
   logic signed [NRM_W-1:0]   nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic                      dg_ff, dg_in;

   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic [SUM_W-1:0]          prod;
   logic                      root_start, root_done;
   logic [ROOT_W-1:0]         root_q;

   logic signed [COORD_W-1:0] cp [3];
   logic signed [COORD_W-1:0] np [3];
   logic signed [COORD_W:0]   dif, add;
   logic [1:0]                tag_c;
   pfn_part_type              tag_p, iss_p;
   logic [SUM_W-1:0]          m_sel;
   logic [SQ_W-1:0]           pp_ext;
   logic [3:0]                tag;

   pfn_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   pfn_root u_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .num   (sq_ff[comp_ff]),
      .den   (len2_ff),
      .done  (root_done),
      .root  (root_q)
   );

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_vld_ff;
   assign rsp_chan.normal_x   = nx_ff;
   assign rsp_chan.normal_y   = ny_ff;
   assign rsp_chan.normal_z   = nz_ff;
   assign rsp_chan.degenerate = dg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         min_len_ff <= '0;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            first_ff[i] <= '0;
            prev_ff[i]  <= '0;
            sum_ff[i]   <= '0;
         end
      end else begin
         state_ff   <= state_in;
         min_len_ff <= min_len_in;
         cnt_ff     <= cnt_in;
         rsp_vld_ff <= rsp_vld_in;
         for (int i = 0; i < 3; i++) begin
            first_ff[i] <= first_in[i];
            prev_ff[i]  <= prev_in[i];
            sum_ff[i]   <= sum_in[i];
         end
      end
      for (int i = 0; i < 3; i++) begin
         cur_ff[i] <= cur_in[i];
         mag_ff[i] <= mag_in[i];
         sq_ff[i]  <= sq_in[i];
         q_ff[i]   <= q_in[i];
      end
      neg_ff   <= neg_in;
      len2_ff  <= len2_in;
      last_ff  <= last_in;
      pair_ff  <= pair_in;
      op_ff    <= op_in;
      comp_ff  <= comp_in;
      degen_ff <= degen_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      nz_ff    <= nz_in;
      dg_ff    <= dg_in;
   end

   always_comb begin
      state_in   = state_ff;
      min_len_in = csr_wr_en ? csr_wr_data : min_len_ff;
      for (int i = 0; i < 3; i++) begin
         first_in[i] = first_ff[i];
         prev_in[i]  = prev_ff[i];
         cur_in[i]   = cur_ff[i];
         sum_in[i]   = sum_ff[i];
         mag_in[i]   = mag_ff[i];
         sq_in[i]    = sq_ff[i];
         q_in[i]     = q_ff[i];
         cp[i]       = pair_ff ? cur_ff[i]   : prev_ff[i];
         np[i]       = pair_ff ? first_ff[i] : cur_ff[i];
      end
      neg_in     = neg_ff;
      len2_in    = len2_ff;
      cnt_in     = cnt_ff;
      last_in    = last_ff;
      pair_in    = pair_ff;
      op_in      = op_ff;
      comp_in    = comp_ff;
      degen_in   = degen_ff;
      nx_in      = nx_ff;
      ny_in      = ny_ff;
      nz_in      = nz_ff;
      dg_in      = dg_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_chan.ready;
      root_start = 1'b0;
      mul_a      = '0;
      mul_b      = '0;

      tag    = op_ff - 4'd1;
      tag_c  = sq_comp(tag);
      tag_p  = sq_part(tag);
      iss_p  = sq_part(op_ff);
      m_sel  = mag_ff[sq_comp(op_ff)];

      // cross term operands: (c.i - n.i) * (c.j + n.j)
      case (op_ff[1:0])
         2'd0: begin
            dif = {cp[1][COORD_W-1], cp[1]} - {np[1][COORD_W-1], np[1]};
            add = {cp[2][COORD_W-1], cp[2]} + {np[2][COORD_W-1], np[2]};
         end
         2'd1: begin
            dif = {cp[2][COORD_W-1], cp[2]} - {np[2][COORD_W-1], np[2]};
            add = {cp[0][COORD_W-1], cp[0]} + {np[0][COORD_W-1], np[0]};
         end
         default: begin
            dif = {cp[0][COORD_W-1], cp[0]} - {np[0][COORD_W-1], np[0]};
            add = {cp[1][COORD_W-1], cp[1]} + {np[1][COORD_W-1], np[1]};
         end
      endcase

      case (tag_p)
         PP_LO_LO: pp_ext = {{SUM_W{1'b0}}, prod};
         PP_HI_LO: pp_ext = {{(SQ_W-SUM_W-MUL_W){1'b0}}, prod, {MUL_W{1'b0}}};
         default:  pp_ext = {prod, {SUM_W{1'b0}}};
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cur_in[0] = req_chan.pos_x;
               cur_in[1] = req_chan.pos_y;
               cur_in[2] = req_chan.pos_z;
               last_in   = req_chan.last_vertex;
               op_in     = '0;
               cnt_in    = (cnt_ff == CNT_W'(MAX_VERTICES)) ? cnt_ff : cnt_ff + CNT_W'(1);
               if (cnt_ff == '0) begin
                  // first vertex opens a polygon: nothing to pair yet
                  for (int i = 0; i < 3; i++) begin
                     first_in[i] = cur_in[i];
                     prev_in[i]  = cur_in[i];
                     sum_in[i]   = '0;
                  end
                  pair_in  = 1'b1;
                  state_in = req_chan.last_vertex ? ST_ACC : ST_IDLE;
               end else begin
                  pair_in  = 1'b0;
                  state_in = ST_ACC;
               end
            end
         end
         ST_ACC: begin
            if (op_ff < ACC_OPS) begin
               mul_a = MUL_W'(dif);
               mul_b = MUL_W'(add);
            end
            if (op_ff != '0) begin
               sum_in[tag[1:0]] = sum_ff[tag[1:0]] + prod;
            end
            op_in = op_ff + 4'd1;
            if (op_ff == ACC_OPS) begin
               op_in = '0;
               if (!pair_ff) begin
                  for (int i = 0; i < 3; i++) prev_in[i] = cur_ff[i];
                  pair_in  = 1'b1;
                  state_in = last_ff ? ST_ACC : ST_IDLE;
               end else begin
                  state_in = ST_MAG;
               end
            end
         end
         ST_MAG: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = sum_ff[i][SUM_W-1];
               mag_in[i] = sum_ff[i][SUM_W-1] ? (~sum_ff[i] + SUM_W'(1)) : sum_ff[i];
               sq_in[i]  = '0;
            end
            len2_in  = '0;
            op_in    = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            // magnitude = hi * 2^28 + lo; square from three partial products
            if (op_ff < SQ_OPS) begin
               case (iss_p)
                  PP_LO_LO: begin
                     mul_a = {1'b0, m_sel[LIMB_W-1:0]};
                     mul_b = {1'b0, m_sel[LIMB_W-1:0]};
                  end
                  PP_HI_LO: begin
                     mul_a = {1'b0, m_sel[SUM_W-1:LIMB_W]};
                     mul_b = {1'b0, m_sel[LIMB_W-1:0]};
                  end
                  default: begin
                     mul_a = {1'b0, m_sel[SUM_W-1:LIMB_W]};
                     mul_b = {1'b0, m_sel[SUM_W-1:LIMB_W]};
                  end
               endcase
            end
            if (op_ff != '0) begin
               sq_in[tag_c] = sq_ff[tag_c] + pp_ext;
               len2_in      = len2_ff + pp_ext;
            end
            op_in = op_ff + 4'd1;
            if (op_ff == SQ_OPS) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            degen_in = (cnt_ff < CNT_W'(3)) ||
                       (len2_ff <= {{(SQ_W-MIN_LEN_W){1'b0}}, min_len_ff});
            comp_in  = '0;
            state_in = degen_in ? ST_OUT : ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            root_start = 1'b1;
            state_in   = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (root_done) begin
               q_in[comp_ff] = root_q;
               comp_in       = comp_ff + 2'd1;
               state_in      = (comp_ff == 2'd2) ? ST_OUT : ST_ROOT_GO;
            end
         end
         ST_OUT: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in = 1'b1;
               dg_in      = degen_ff;
               if (degen_ff) begin
                  nx_in = '0;
                  ny_in = NRM_W'(ONE_Q14);
                  nz_in = '0;
               end else begin
                  nx_in = neg_ff[0] ? -NRM_W'(q_ff[0]) : NRM_W'(q_ff[0]);
                  ny_in = neg_ff[1] ? -NRM_W'(q_ff[1]) : NRM_W'(q_ff[1]);
                  nz_in = neg_ff[2] ? -NRM_W'(q_ff[2]) : NRM_W'(q_ff[2]);
               end
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ----- tb/polygon_face_normal_tb.sv -----
// polygon_face_normal_tb: self-checking bench for the Newell face normal block.
// Depends on pfn_pkg, pfn_req_if, pfn_rsp_if and polygon_face_normal.
// Streams polygons as vertex requests and checks each normal against a local predictor.
module polygon_face_normal_tb;
   import pfn_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;   // cycles with no handshake at all
   localparam int DRAIN_CYCLES   = 250;     // longer than one full last-vertex pass

   typedef struct {
      logic signed [COORD_W-1:0] x, y, z;
      logic                      last;
   } vertex_type;

   typedef struct {
      logic signed [NRM_W-1:0] nx, ny, nz;
      logic                    degen;
   } face_normal_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [MIN_LEN_W-1:0] csr_wr_data;

   pfn_req_if req_chan ();
   pfn_rsp_if rsp_chan ();

   polygon_face_normal u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // clock: period 8
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   vertex_type      vertex_queue[$];    // requests not yet driven
   face_normal_type normal_queue[$];    // normals predicted, not yet seen
   int              idle_pct;
   int              stall_pct;
   int              errors = 0;
   int              polygons_seen = 0;
   int              degen_seen = 0;
   int              idle_cycles;

   // predictor state, mirrors the block's polygon state
   logic [MIN_LEN_W-1:0] min_len_sq;
   logic [63:0]          first_pos[3];
   logic [63:0]          prev_pos[3];
   logic [SUM_W-1:0]     newell_sum[3];
   int                   vertex_cnt = 0;

   // Add one pair's three cross terms; products are taken mod 2^64, then wrapped.
   task automatic add_cross_terms(input logic [63:0] c[3], input logic [63:0] n[3]);
      logic [63:0] t0, t1, t2;
      t0 = (c[1] - n[1]) * (c[2] + n[2]);
      t1 = (c[2] - n[2]) * (c[0] + n[0]);
      t2 = (c[0] - n[0]) * (c[1] + n[1]);
      newell_sum[0] = newell_sum[0] + t0[SUM_W-1:0];
      newell_sum[1] = newell_sum[1] + t1[SUM_W-1:0];
      newell_sum[2] = newell_sum[2] + t2[SUM_W-1:0];
   endtask

   // Largest q <= 1.0 in Q1.14 with q^2 * len2 <= mag^2 * 2^28 (exact truncation).
   function automatic logic [14:0] unit_component(input logic [191:0] mag,
                                                  input logic [191:0] len2);
      logic [191:0] bound;
      logic [191:0] trial;
      logic [14:0]  q;
      logic [15:0]  t;
      bound = (mag * mag) << 28;
      q = '0;
      for (int b = 14; b >= 0; b--) begin
         t = {1'b0, q} | (16'd1 << b);
         if (t <= ONE_Q14) begin
            trial = 192'(t) * 192'(t) * len2;
            if (trial <= bound) q = t[14:0];
         end
      end
      return q;
   endfunction

   // Feed one accepted vertex to the predictor; a last vertex yields a normal.
   task automatic predict_vertex(input vertex_type v);
      logic [63:0]  p[3];
      logic [191:0] mag[3];
      logic [191:0] len2;
      logic [SUM_W-1:0] s;
      logic [SUM_W-1:0] sn;
      logic         neg[3];
      logic [14:0]  q;
      face_normal_type r;
      p[0] = 64'(v.x);
      p[1] = 64'(v.y);
      p[2] = 64'(v.z);
      if (vertex_cnt == 0) begin
         first_pos = p;
         for (int k = 0; k < 3; k++) newell_sum[k] = '0;
      end else begin
         add_cross_terms(prev_pos, p);
      end
      prev_pos = p;
      if (vertex_cnt < MAX_VERTICES) vertex_cnt++;
      if (!v.last) return;
      add_cross_terms(p, first_pos);     // closing pair back to the first vertex
      len2 = '0;
      for (int k = 0; k < 3; k++) begin
         s = newell_sum[k];
         sn = ~s + 1'b1;                 // magnitude formed at accumulator width
         neg[k] = s[SUM_W-1];
         mag[k] = neg[k] ? 192'(sn) : 192'(s);
         if (neg[k] && mag[k] == 0) mag[k] = 192'(1) << (SUM_W - 1);
         len2 = len2 + mag[k] * mag[k];
      end
      if (vertex_cnt < 3 || len2 <= 192'(min_len_sq)) begin
         r.nx = '0;
         r.ny = 16'(ONE_Q14);
         r.nz = '0;
         r.degen = 1'b1;
      end else begin
         q = unit_component(mag[0], len2);
         r.nx = neg[0] ? -$signed({1'b0, q}) : $signed({1'b0, q});
         q = unit_component(mag[1], len2);
         r.ny = neg[1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
         q = unit_component(mag[2], len2);
         r.nz = neg[2] ? -$signed({1'b0, q}) : $signed({1'b0, q});
         r.degen = 1'b0;
      end
      normal_queue = {normal_queue, r};
      vertex_cnt = 0;
      for (int k = 0; k < 3; k++) newell_sum[k] = '0;
   endtask

   // Request driver: hold the payload until taken, then maybe idle.
   always @(posedge clock) begin
      vertex_type v;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (vertex_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
            v = vertex_queue.pop_front();
            req_chan.pos_x       <= v.x;
            req_chan.pos_y       <= v.y;
            req_chan.pos_z       <= v.z;
            req_chan.last_vertex <= v.last;
            req_chan.valid       <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response side backpressure.
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else       rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Monitor: predict on accepted requests, check accepted responses in order.
   always @(posedge clock) begin
      vertex_type      v;
      face_normal_type e;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            v.x    = req_chan.pos_x;
            v.y    = req_chan.pos_y;
            v.z    = req_chan.pos_z;
            v.last = req_chan.last_vertex;
            predict_vertex(v);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            polygons_seen++;
            if (rsp_chan.degenerate) degen_seen++;
            if (normal_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected normal (%0d,%0d,%0d) degen=%0b", $time,
                        rsp_chan.normal_x, rsp_chan.normal_y, rsp_chan.normal_z,
                        rsp_chan.degenerate);
            end else begin
               e = normal_queue.pop_front();
               if (rsp_chan.normal_x !== e.nx || rsp_chan.normal_y !== e.ny ||
                   rsp_chan.normal_z !== e.nz || rsp_chan.degenerate !== e.degen) begin
                  errors++;
                  $display("%0t: mismatch exp (%0d,%0d,%0d,%0b) got (%0d,%0d,%0d,%0b)",
                           $time, e.nx, e.ny, e.nz, e.degen, rsp_chan.normal_x,
                           rsp_chan.normal_y, rsp_chan.normal_z, rsp_chan.degenerate);
               end
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d normals outstanding", $time,
                  normal_queue.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_vertex(input int x, input int y, input int z, input bit last);
      vertex_type v;
      v.x = x[COORD_W-1:0];
      v.y = y[COORD_W-1:0];
      v.z = z[COORD_W-1:0];
      v.last = last;
      vertex_queue = {vertex_queue, v};
   endtask

   // Random polygon; span picks full-range, mid-range or tiny coordinates.
   task automatic queue_polygon(input int n, input int span);
      int lim;
      case (span)
         0:       lim = 8388607;
         1:       lim = 65536;
         default: lim = 7;
      endcase
      for (int i = 0; i < n; i++) begin
         if (span == 0)
            queue_vertex($urandom, $urandom, $urandom, i == n - 1);
         else
            queue_vertex($urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
                         $urandom_range(2 * lim) - lim, i == n - 1);
      end
   endtask

   // Only when the block is idle: nothing queued, in flight or expected.
   task automatic wait_idle();
      while (vertex_queue.size() > 0 || req_chan.valid || normal_queue.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_len(input logic [MIN_LEN_W-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      min_len_sq = val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int n;
      int pick;
      logic [MIN_LEN_W-1:0] thresholds[5];
      idle_pct = 0;
      stall_pct = 0;
      min_len_sq = '0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      thresholds[0] = '0;
      thresholds[1] = 20'hFFFFF;
      thresholds[2] = 20'd1;
      thresholds[3] = $urandom_range(20'hFFFFF);
      thresholds[4] = $urandom_range(4096);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 5; ph++) begin
         // idling mix per phase: none, slow sender, slow receiver, both
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 84; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 84; end
            default: begin idle_pct = 31; stall_pct = 31; end
         endcase
         write_min_len(thresholds[ph]);
         if (ph == 0) begin
            // unit z triangle: exact 1.0 component
            queue_vertex(0, 0, 0, 0);
            queue_vertex(4096, 0, 0, 0);
            queue_vertex(0, 4096, 0, 1);
            // extreme corners
            queue_vertex(8388607, -8388608, 8388607, 0);
            queue_vertex(-8388608, 8388607, -8388608, 0);
            queue_vertex(8388607, 8388607, -8388608, 1);
            // single vertex and two-vertex loops fall back
            queue_vertex(-8388608, -8388608, -8388608, 1);
            queue_vertex(100, 200, 300, 0);
            queue_vertex(-5, 7, 9, 1);
            // collinear triangle: zero length
            queue_vertex(0, 0, 0, 0);
            queue_vertex(1000, 1000, 1000, 0);
            queue_vertex(2000, 2000, 2000, 1);
            // negative normal, tiny coordinates
            queue_vertex(0, 0, 0, 0);
            queue_vertex(0, 1, 0, 0);
            queue_vertex(1, 0, 0, 1);
            // a loop past the vertex count saturation
            queue_polygon(70, 1);
         end
         n = 0;
         while (n < 370) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               queue_polygon($urandom_range(1, 2), $urandom_range(2));
               n += 2;
            end else if (pick < 10) begin
               queue_polygon($urandom_range(65, 80), $urandom_range(1));
               n += 70;
            end else begin
               queue_polygon($urandom_range(3, 8), $urandom_range(2));
               n += 5;
            end
         end
         wait_idle();
      end

      $display("Ran %0d polygon normals (%0d fallback) over 5 threshold settings",
               polygons_seen, degen_seen);
      $display("with sender idling and receiver stalls varied per phase");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/pfn_pkg.sv
rtl/pfn_req_if.sv
rtl/pfn_rsp_if.sv
rtl/pfn_mul.sv
rtl/pfn_root.sv
rtl/polygon_face_normal.sv
tb/polygon_face_normal_tb.sv
